>>> src/qtbe_pkg.sv
// Shared constants, types and helper functions of the quadtree bitmap encoder.
// Has no dependencies; every other file of the block imports it.
package qtbe_pkg;

    localparam int MAX_DIM     = 256;
    localparam int STACK_DEPTH = 32;

    localparam int DIM_W   = 9;
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int PIX_AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W   = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic PH_LOADING = 1'b0;
    localparam logic PH_CODING  = 1'b1;

    localparam logic [SYM_W-1:0] SYM_ZERO   = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE    = 2'd1;
    localparam logic [SYM_W-1:0] SYM_DIVIDE = 2'd2;
    localparam logic [SYM_W-1:0] SYM_NONE   = 2'd3;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic [DIM_W-1:0]   end_r;
        logic [DIM_W-1:0]   end_c;
    } region_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

>>> src/quadtree_bitmap_encoder_top.sv
// Quadtree bitmap encoder: pixel store, region stack and the scan sequencer.
// Depends on qtbe_pkg.
//
// Channel  Direction  Handshake                Content
// s_axis   in         s_axis_tvalid/tready     tdata: pixel; tuser: operation
// m_axis   out        m_axis_tvalid/tready     tdata: symbol; tlast: last
// apb      in         psel/penable/pwrite      rows at 0x0, cols at 0x4
//
// A load item while loading is written to the pixel store when it is accepted. A fetch while loading answers at once.
// A fetch while coding pops a region, reads each pixel that the region scan needs from
// the single-port pixel store in turn, and pushes the quadrants when the region
// divides. A result that waits on the output holds the input not ready.
// Reset is asynchronous; the pixel store and region stack need no clearing.
module quadtree_bitmap_encoder_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [0] pixel, [7:1] zero
    input  logic [0:0]              s_axis_tuser,   // [0] operation
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [1:0] symbol, [7:2] zero
    output logic                    m_axis_tlast,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import qtbe_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GETREG = 3'd1;
    localparam logic [2:0] ST_ADDR   = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_PUSH   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [CNT_W-1:0]   lc_reg, lc_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [DIM_W-1:0]   rows_reg, cols_reg;
    logic [COORD_W-1:0] t_reg, t_next, l_reg, l_next, r_reg, r_next, c_reg, c_next;
    logic [DIM_W-1:0]   er_reg, er_next, ec_reg, ec_next;
    logic [DIM_W-1:0]   mr_reg, mr_next, mc_reg, mc_next;
    logic               first_reg, first_next, ffirst_reg, ffirst_next;
    logic               mixed_reg, mixed_next;
    logic [1:0]         pidx_reg, pidx_next;
    logic [SYM_W-1:0]   psym_reg, psym_next;
    logic               plast_reg, plast_next;
    logic               ov_reg, ov_next;
    logic [SYM_W-1:0]   osym_reg, osym_next;
    logic               olast_reg, olast_next;

    logic               pix_mem [MAX_DIM*MAX_DIM];
    logic               pix_q_reg;
    logic               pix_we;
    logic [PIX_AW-1:0]  pix_raddr;
    region_t            stk_mem [STACK_DEPTH];
    region_t            stk_q_reg;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    region_t            stk_wdata;
    logic [STK_AW-1:0]  stk_raddr;

    logic [DIM_W-1:0]   nr, nc;
    logic [CNT_W-1:0]   total, lc_inc;
    logic [2*DIM_W-1:0] dim_prod;
    logic [2*DIM_W-1:0] row_base;
    logic               cfg_wr, accept, slot_free, diff, end_cell;
    logic               has_right, has_bottom, push_en;
    region_t            push_ent;
    logic [DIM_W-1:0]   half_r, half_c;

    assign nr        = eff_dim(rows_reg);
    assign nc        = eff_dim(cols_reg);
    assign dim_prod  = {{DIM_W{1'b0}}, nr} * {{DIM_W{1'b0}}, nc};
    assign total     = dim_prod[CNT_W-1:0];
    assign lc_inc    = lc_reg + CNT_W'(1);
    assign row_base  = {{(DIM_W+1){1'b0}}, r_reg} * {{DIM_W{1'b0}}, nc};
    assign pix_raddr = PIX_AW'(row_base + (2*DIM_W)'(c_reg));
    assign stk_raddr = STK_AW'(sp_reg - SP_W'(1));

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_COLS) ? 32'(cols_reg) : 32'(rows_reg);

    assign slot_free     = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = 8'(osym_reg);
    assign m_axis_tlast  = olast_reg;

    assign diff      = !ffirst_reg && (pix_q_reg != first_reg);
    assign end_cell  = (DIM_W'(c_reg) + DIM_W'(1) == ec_reg) &&
                       (DIM_W'(r_reg) + DIM_W'(1) == er_reg);
    assign half_r    = (er_reg - DIM_W'(t_reg)) >> 1;
    assign half_c    = (ec_reg - DIM_W'(l_reg)) >> 1;
    assign has_right  = (mc_reg != ec_reg);
    assign has_bottom = (mr_reg != er_reg);

    always_comb
    begin
        unique case (pidx_reg)
            2'd0:
            begin
                push_en  = has_right && has_bottom;
                push_ent = '{COORD_W'(mr_reg), COORD_W'(mc_reg), er_reg, ec_reg};
            end
            2'd1:
            begin
                push_en  = has_bottom;
                push_ent = '{COORD_W'(mr_reg), l_reg, er_reg, mc_reg};
            end
            2'd2:
            begin
                push_en  = has_right;
                push_ent = '{t_reg, COORD_W'(mc_reg), mr_reg, ec_reg};
            end
            default:
            begin
                push_en  = 1'b1;
                push_ent = '{t_reg, l_reg, mr_reg, mc_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[lc_reg[PIX_AW-1:0]] <= s_axis_tdata[0];
        end
        pix_q_reg <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(1);
            cols_reg <= DIM_W'(1);
        end
        else if (cfg_wr && phase_reg == PH_LOADING && lc_reg == '0)
        begin
            if (paddr[2] == REG_ROWS)
                rows_reg <= pwdata[DIM_W-1:0];
            else
                cols_reg <= pwdata[DIM_W-1:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        lc_next     = lc_reg;
        sp_next     = sp_reg;
        t_next      = t_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        er_next     = er_reg;
        ec_next     = ec_reg;
        mr_next     = mr_reg;
        mc_next     = mc_reg;
        first_next  = first_reg;
        ffirst_next = ffirst_reg;
        mixed_next  = mixed_reg;
        pidx_next   = pidx_reg;
        psym_next   = psym_reg;
        plast_next  = plast_reg;
        ov_next     = ov_reg && !m_axis_tready;
        osym_next   = osym_reg;
        olast_next  = olast_reg;
        pix_we      = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[STK_AW-1:0];
        stk_wdata   = push_ent;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tuser[0] == OP_LOAD && phase_reg == PH_LOADING)
                begin
                    if (lc_reg < total)
                    begin
                        pix_we  = 1'b1;
                        lc_next = lc_inc;
                    end
                    if (lc_inc >= total)
                    begin
                        phase_next = PH_CODING;
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = '{'0, '0, nr, nc};
                        sp_next    = SP_W'(1);
                    end
                end
                else if (accept && s_axis_tuser[0] == OP_FETCH)
                begin
                    if (phase_reg != PH_CODING || sp_reg == '0)
                    begin
                        ov_next    = 1'b1;
                        osym_next  = SYM_NONE;
                        olast_next = 1'b0;
                    end
                    else
                    begin
                        sp_next    = sp_reg - SP_W'(1);
                        state_next = ST_GETREG;
                    end
                end
            end
            ST_GETREG:
            begin
                t_next      = stk_q_reg.top;
                l_next      = stk_q_reg.left;
                er_next     = stk_q_reg.end_r;
                ec_next     = stk_q_reg.end_c;
                r_next      = stk_q_reg.top;
                c_next      = stk_q_reg.left;
                ffirst_next = 1'b1;
                mixed_next  = 1'b0;
                state_next  = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (ffirst_reg)
                    first_next = pix_q_reg;
                ffirst_next = 1'b0;
                mixed_next  = diff;
                if (diff || end_cell)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    if (DIM_W'(c_reg) + DIM_W'(1) == ec_reg)
                    begin
                        c_next = l_reg;
                        r_next = r_reg + COORD_W'(1);
                    end
                    else
                    begin
                        c_next = c_reg + COORD_W'(1);
                    end
                    state_next = ST_ADDR;
                end
            end
            ST_DECIDE:
            begin
                if (mixed_reg)
                begin
                    mr_next    = er_reg - half_r;
                    mc_next    = ec_reg - half_c;
                    pidx_next  = '0;
                    state_next = ST_PUSH;
                end
                else
                begin
                    psym_next  = first_reg ? SYM_ONE : SYM_ZERO;
                    plast_next = (sp_reg == '0);
                    if (sp_reg == '0)
                    begin
                        phase_next = PH_LOADING;
                        lc_next    = '0;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_PUSH:
            begin
                if (push_en && sp_reg < SP_W'(STACK_DEPTH))
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + SP_W'(1);
                end
                pidx_next = pidx_reg + 2'd1;
                if (pidx_reg == 2'd3)
                begin
                    psym_next  = SYM_DIVIDE;
                    plast_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    osym_next  = psym_reg;
                    olast_next = plast_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LOADING;
            lc_reg    <= '0;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lc_reg    <= lc_next;
            sp_reg    <= sp_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        er_reg     <= er_next;
        ec_reg     <= ec_next;
        mr_reg     <= mr_next;
        mc_reg     <= mc_next;
        first_reg  <= first_next;
        ffirst_reg <= ffirst_next;
        mixed_reg  <= mixed_next;
        pidx_reg   <= pidx_next;
        psym_reg   <= psym_next;
        plast_reg  <= plast_next;
        osym_reg   <= osym_next;
        olast_reg  <= olast_next;
    end

endmodule

>>> src/qtbe_checker.sv
// Port-level checks of the quadtree bitmap encoder, bound to the top level.
// Depends on qtbe_pkg and quadtree_bitmap_encoder_top.
module qtbe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       pready
);
    import qtbe_pkg::*;

    a_last_is_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] != SYM_DIVIDE
            && m_axis_tdata[1:0] != SYM_NONE)
        else $error("Final symbol is not a leaf value.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("Input taken while the output item is stalled.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("Stalled output item changed.");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("Configuration port not ready.");

endmodule

bind quadtree_bitmap_encoder_top qtbe_checker u_qtbe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

>>> bench/tb.sv
// Self-checking bench for the quadtree bitmap encoder: loads bitmaps, fetches the code
// and compares every symbol with a predictor held in a scoreboard class.
// Depends on qtbe_pkg and quadtree_bitmap_encoder_top.
module tb;
    import qtbe_pkg::*;

    localparam int LIMIT = 2000000;

    typedef struct {
        int top;
        int left;
        int end_r;
        int end_c;
    } area_t;

    typedef struct {
        logic [SYM_W-1:0] sym;
        bit               last;
    } code_t;

    class code_scoreboard;
        bit          pixels[MAX_DIM*MAX_DIM];
        int          loaded;
        bit          coding;
        area_t       areas[STACK_DEPTH];
        int          depth;
        logic [8:0]  rows_reg = 9'd1;
        logic [8:0]  cols_reg = 9'd1;
        code_t       codes[$];
        int          errors;

        function int dim(logic [8:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIM)
                return MAX_DIM;
            return int'(v);
        endfunction

        function void write_reg(logic idx, logic [8:0] v);
            if (coding || loaded != 0)
                return;
            if (idx == REG_ROWS)
                rows_reg = v;
            else
                cols_reg = v;
        endfunction

        function void push_area(int t, int l, int er, int ec);
            if (depth >= STACK_DEPTH)
                return;
            areas[depth] = '{t, l, er, ec};
            depth++;
        endfunction

        function void add_code(logic [SYM_W-1:0] s, bit l);
            code_t e;
            e.sym  = s;
            e.last = l;
            codes.insert(codes.size(), e);
        endfunction

        function void note_input(logic op, bit px);
            int    nr;
            int    nc;
            area_t g;
            bit    first;
            bit    mixed;
            int    mr;
            int    mc;
            nr = dim(rows_reg);
            nc = dim(cols_reg);
            if (op == OP_LOAD) begin
                if (coding)
                    return;
                if (loaded < nr * nc) begin
                    pixels[loaded] = px;
                    loaded++;
                end
                if (loaded >= nr * nc) begin
                    coding = 1'b1;
                    depth = 0;
                    push_area(0, 0, nr, nc);
                end
                return;
            end
            if (!coding || depth == 0) begin
                add_code(SYM_NONE, 1'b0);
                return;
            end
            depth--;
            g = areas[depth];
            first = pixels[g.top * nc + g.left];
            mixed = 1'b0;
            for (int r = g.top; r < g.end_r && !mixed; r++)
                for (int c = g.left; c < g.end_c && !mixed; c++)
                    if (pixels[r * nc + c] != first)
                        mixed = 1'b1;
            if (mixed) begin
                mr = g.end_r - (g.end_r - g.top) / 2;
                mc = g.end_c - (g.end_c - g.left) / 2;
                if (mc != g.end_c && mr != g.end_r)
                    push_area(mr, mc, g.end_r, g.end_c);
                if (mr != g.end_r)
                    push_area(mr, g.left, g.end_r, mc);
                if (mc != g.end_c)
                    push_area(g.top, mc, mr, g.end_c);
                push_area(g.top, g.left, mr, mc);
                add_code(SYM_DIVIDE, 1'b0);
                return;
            end
            if (depth == 0) begin
                add_code(first ? SYM_ONE : SYM_ZERO, 1'b1);
                coding = 1'b0;
                loaded = 0;
            end else begin
                add_code(first ? SYM_ONE : SYM_ZERO, 1'b0);
            end
        endfunction

        function void check_result(logic [7:0] data, logic last);
            code_t e;
            if (codes.size() == 0) begin
                $display("%0t: unexpected item, expected none, got symbol %0d last %0d",
                         $time, data, last);
                errors++;
                return;
            end
            e = codes.pop_front();
            if (data !== {6'b0, e.sym} || last !== e.last) begin
                $display("%0t: mismatch, expected symbol %0d last %0d, got data %0h last %0b",
                         $time, e.sym, e.last, data, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    code_scoreboard sb = new();
    int  cycles;
    int  items;
    bit  quiet;
    int  stall;

    quadtree_bitmap_encoder_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall <= 0;
            cycles <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (stall > 0) begin
                stall <= stall - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 30) begin
                stall <= pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send(logic op, bit px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'b0, px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(op, px);
        items++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.codes.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'($urandom_range(0, 8388607)), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    function bit pattern_pixel(int kind, int idx, int nr, int nc, bit base);
        int r;
        int c;
        r = idx / nc;
        c = idx % nc;
        case (kind)
            0: return base;
            1: return 1'($urandom_range(0, 1));
            2: return base ^ ((r * 2 / nr) == 1 && (c * 2 / nc) == 1);
            default: return ($urandom_range(0, 19) == 0) ^ base;
        endcase
    endfunction

    task automatic run_bitmap(logic [8:0] r, logic [8:0] c, int kind, bit noisy);
        int  nr;
        int  nc;
        bit  base;
        drain();
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
        nr = sb.dim(r);
        nc = sb.dim(c);
        base = 1'($urandom_range(0, 1));
        for (int i = 0; i < nr * nc; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send(OP_FETCH, 1'($urandom_range(0, 1)));
            if (noisy && i == 1 && $urandom_range(0, 3) == 0) begin
                drain();
                write_reg(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)));
            end
            send(OP_LOAD, pattern_pixel(kind, i, nr, nc, base));
        end
        while (sb.coding) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send(OP_LOAD, 1'($urandom_range(0, 1)));
            send(OP_FETCH, 1'($urandom_range(0, 1)));
        end
        if (noisy && $urandom_range(0, 5) == 0)
            send(OP_FETCH, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items = 0;
        quiet = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset dimensions: a single cell, fetched with nothing loaded, then loaded and fetched, then fetched again.
        send(OP_FETCH, 1'b1);
        send(OP_LOAD, 1'b1);
        send(OP_FETCH, 1'b0);
        send(OP_FETCH, 1'b0);
        run_bitmap(9'd0, 9'd0, 0, 1'b0);
        run_bitmap(9'd2, 9'd3, 1, 1'b0);
        run_bitmap(9'd3, 9'd2, 2, 1'b0);
        drain();
        write_reg(REG_ROWS, 9'd2);
        write_reg(REG_COLS, 9'd2);
        send(OP_LOAD, 1'b0);
        drain();
        write_reg(REG_COLS, 9'd5);
        send(OP_FETCH, 1'b1);
        send(OP_LOAD, 1'b1);
        send(OP_LOAD, 1'b0);
        send(OP_LOAD, 1'b1);
        send(OP_FETCH, 1'b0);
        send(OP_LOAD, 1'b1);
        send(OP_FETCH, 1'b0);
        send(OP_FETCH, 1'b0);

        n = 0;
        while (items < 720) begin
            quiet = ($urandom_range(0, 5) == 0);
            if (n == 3)
                run_bitmap(9'd511, 9'd1, 3, 1'b1);
            else if (n == 8)
                run_bitmap(9'd1, 9'd256, 2, 1'b1);
            else if (n == 12)
                run_bitmap(9'd256, 9'd2, 0, 1'b1);
            else if ($urandom_range(0, 9) == 0)
                run_bitmap(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                           $urandom_range(0, 3), 1'b1);
            else
                run_bitmap(9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)),
                           $urandom_range(0, 3), 1'b1);
            n++;
        end
        quiet = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.codes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
